// File: rtl/fene_pkg.sv
// Shared types, codes and constants of the FENE bond energy unit.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package fene_pkg;

    // Field widths fixed by the bus format.
    localparam int NUM_TYPES  = 4;
    localparam int TYPE_W     = 2;
    localparam int LEN_W      = 24;
    localparam int ENERGY_W   = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [63:0] COEFF_RESET  = 64'd72058694052872576;
    localparam logic [15:0] CUTOFF_RESET = 16'd4598;
    // ln(2) in Q0.30.
    localparam logic [29:0] LN2_Q30      = 30'd744261118;

    // Queue between the front and the back end.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Back end stage map.
    localparam int QDIV_N        = 32;               // quotient bits of r^2/r0^2
    localparam int SDIV_N        = 28;               // quotient bits of sigma/r
    localparam int NORM_N        = 5;                // binary normalisation steps
    localparam int SQ_N          = 28;               // log2 squaring steps
    localparam int STG_S2        = SDIV_N + 1;
    localparam int STG_S4        = STG_S2 + 1;
    localparam int STG_S6P       = STG_S4 + 1;
    localparam int STG_S6        = STG_S6P + 1;
    localparam int STG_T         = STG_S6 + 1;
    localparam int STG_T2P       = STG_T + 1;
    localparam int STG_T2        = STG_T2P + 1;
    localparam int STG_EP        = STG_T2 + 1;
    localparam int STG_WCA_END   = STG_EP + 1;
    localparam int STG_Y         = QDIV_N + 1;
    localparam int STG_NORM_LAST = STG_Y + NORM_N;
    localparam int STG_SQ_LAST   = STG_NORM_LAST + SQ_N;
    localparam int STG_LSUM      = STG_SQ_LAST + 1;
    localparam int STG_NL        = STG_LSUM + 1;
    localparam int STG_SP0       = STG_NL + 1;
    localparam int STG_SP1       = STG_SP0 + 1;
    localparam int STG_LAST      = STG_SP1 + 1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_STRETCH = 2'd1,
        ST_OVER    = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COEFF0 = 3'd0,
        CFG_COEFF1 = 3'd1,
        CFG_COEFF2 = 3'd2,
        CFG_COEFF3 = 3'd3,
        CFG_CUTOFF = 3'd4
    } cfg_reg_t;

    // One classified bond as it waits in the queue.
    typedef struct packed {
        status_t           spec;
        logic              wca_en;
        logic              s_ovf;
        logic [LEN_W-1:0]  r;
        logic [15:0]       eps;
        logic [15:0]       sig;
        logic [15:0]       kf;
        logic [31:0]       r0sq;
    } bond_item_t;

    // Values that ride along the whole back end pipeline.
    typedef struct packed {
        status_t              spec;
        logic                 wca_en;
        logic                 s_ovf;
        logic [15:0]          eps;
        logic [LEN_W-1:0]     r;
        logic [31:0]          r0sq;
        logic [47:0]          akr;
        logic [ENERGY_W-1:0]  wca;
        logic                 wov;
    } back_ctl_t;

endpackage

`default_nettype wire

// File: rtl/fene_bond_energy_top.sv
// Top level of the FENE bond energy unit: stream ports, configuration port and the
// front end, queue and back end. Depends on fene_pkg, fene_front, fene_queue, fene_back.
`default_nettype none

// The unit takes one bond per transfer (type on tuser, Q8.16 length on tdata) and
// returns one transfer with the Q32.16 energy on tdata and the status on tuser.
// It accepts a new bond every clock cycle and delivers one result per cycle while
// the output side keeps tready high. An accepted bond passes through the queue,
// 72 pipeline stages and the output register. The pipeline depth is set by the
// 32-step restoring division of r^2 by r0^2, the five normalisation steps and the
// 28 squaring steps of the base-two logarithm, and the
// split wide multiply that scales the logarithm by kf*r0^2. The WCA core term runs
// alongside in a 28-step division of sigma by r and a chain of multipliers. The
// front end keeps the coefficient registers and classifies each bond (zero length,
// overstretch, inside the WCA cutoff); a four-entry queue lets the input keep
// flowing while the output is stalled. Configuration writes are always taken and
// must only be made while no bond is in flight.

module fene_bond_energy_top
    import fene_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Input stream.
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [LEN_W-1:0]      s_axis_tdata,   // [23:0] bond_length
    input  wire logic [TYPE_W-1:0]     s_axis_tuser,   // [1:0] bond_type
    // Output stream.
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [ENERGY_W-1:0]        m_axis_tdata,   // [47:0] energy
    output logic [1:0]                 m_axis_tuser,   // [1:0] status
    // Configuration writes.
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    bond_item_t wr_item, head;
    logic       q_push, q_full, q_pop, head_valid;
    status_t    status;

    fene_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .bond_type   (s_axis_tuser),
        .bond_length (s_axis_tdata),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_item      (wr_item)
    );

    fene_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .wr_item    (wr_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head       (head)
    );

    fene_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (q_pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .energy     (m_axis_tdata),
        .status     (status)
    );

    assign m_axis_tuser = status;

endmodule

`default_nettype wire

// File: rtl/fene_front.sv
// Front end: coefficient registers, configuration port and bond classification.
// Depends on fene_pkg.
`default_nettype none

module fene_front
    import fene_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [TYPE_W-1:0]     bond_type,
    input  wire logic [LEN_W-1:0]      bond_length,
    input  wire logic                  q_full,
    output logic                       q_push,
    output bond_item_t                 q_item
);

    logic [CFG_DATA_W-1:0] coeff_reg [0:3];
    logic [15:0]           cutoff_reg;

    logic [TYPE_W-1:0] sel;
    logic [63:0]       c;
    logic [15:0]       eps, sig, kf, r0;
    logic [31:0]       cut_prod;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                coeff_reg[i] <= COEFF_RESET;
            end
            cutoff_reg <= CUTOFF_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index) inside
                CFG_COEFF0, CFG_COEFF1, CFG_COEFF2, CFG_COEFF3:
                    coeff_reg[cfg_index[1:0]] <= cfg_data;
                CFG_CUTOFF:
                    cutoff_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Types past the configured count fall back on the last one.
    always_comb
    begin
        if ({1'b0, bond_type} >= 3'(NUM_TYPES))
            sel = TYPE_W'(NUM_TYPES - 1);
        else
            sel = bond_type;
        c        = coeff_reg[sel];
        eps      = c[63:48];
        sig      = c[47:32];
        kf       = c[31:16];
        r0       = c[15:0];
        cut_prod = cutoff_reg * sig;
    end

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        q_item.r      = bond_length;
        q_item.eps    = eps;
        q_item.sig    = sig;
        q_item.kf     = kf;
        q_item.r0sq   = r0 * r0;
        q_item.wca_en = (32'({bond_length, 4'b0000}) < cut_prod) && (eps != 16'd0);
        q_item.s_ovf  = (24'({sig, 4'b0000}) >= bond_length);
        if (bond_length == '0)
            q_item.spec = ST_OVER;
        else if (bond_length >= {r0, 8'b0})
            q_item.spec = ST_STRETCH;
        else
            q_item.spec = ST_OK;
    end

endmodule

`default_nettype wire

// File: rtl/fene_queue.sv
// Short queue of classified bonds between the front and the back end.
// Depends on fene_pkg.
`default_nettype none

module fene_queue
    import fene_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  bond_item_t      wr_item,
    output logic            full,
    input  wire logic       pop,
    output logic            head_valid,
    output bond_item_t      head
);

    bond_item_t          slot_reg [0:QUEUE_DEPTH-1];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg, count_next;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= wr_item;
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n) full |-> !push)
        else $error("queue written while full");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("queue read while empty");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

`default_nettype wire

// File: rtl/fene_back.sv
// Back end: pipelined spring and WCA energy evaluation with output register.
// Depends on fene_pkg.
`default_nettype none

module fene_back
    import fene_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 head_valid,
    input  bond_item_t                head,
    output logic                      pop,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [ENERGY_W-1:0]       energy,
    output status_t                   status
);

    typedef struct packed {
        logic [31:0] m;
        logic [4:0]  k;
        logic        one;
        logic [27:0] frac;
    } log_t;

    logic adv;

    logic      vld_reg [0:STG_LAST];
    back_ctl_t ctl_reg [0:STG_LAST];

    logic [47:0]       qrem_reg [0:QDIV_N];
    logic [31:0]       qquo_reg [0:QDIV_N];
    logic [LEN_W-1:0]  srem_reg [0:SDIV_N];
    logic [SDIV_N-1:0] squo_reg [0:SDIV_N];
    log_t              lg_reg   [STG_Y:STG_SQ_LAST];

    logic [31:0] s2_reg, s2b_reg;
    logic [39:0] s4_reg;
    logic [63:0] plo_reg;
    logic [39:0] phi_reg;
    logic [47:0] s6_reg;
    logic [48:0] t_reg;
    logic [63:0] pll_reg;
    logic [48:0] plh_reg;
    logic [33:0] phh_reg;
    logic [63:0] t2_reg;
    logic [47:0] e0_reg, e1_reg;
    logic [33:0] lsum_reg;
    logic        lone_reg;
    logic [36:0] nl_reg;
    logic [42:0] pp0_reg, pp2_reg;
    logic [41:0] pp1_reg, pp3_reg;
    logic [61:0] sp0_reg, sp1_reg;
    logic [44:0] spring_reg;

    logic                out_valid_reg;
    logic [ENERGY_W-1:0] energy_reg, energy_next;
    status_t             status_reg, status_next;

    back_ctl_t ctl0_next;

    assign adv       = !out_valid_reg || out_ready;
    assign pop       = adv && head_valid;
    assign out_valid = out_valid_reg;
    assign energy    = energy_reg;
    assign status    = status_reg;

    // Entry stage.
    always_comb
    begin
        ctl0_next.spec   = head.spec;
        ctl0_next.wca_en = head.wca_en;
        ctl0_next.s_ovf  = head.s_ovf;
        ctl0_next.eps    = head.eps;
        ctl0_next.r      = head.r;
        ctl0_next.r0sq   = head.r0sq;
        ctl0_next.akr    = head.kf * head.r0sq;
        ctl0_next.wca    = '0;
        ctl0_next.wov    = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (adv)
            vld_reg[0] <= head_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctl_reg[0]  <= ctl0_next;
            qrem_reg[0] <= head.r * head.r;
            qquo_reg[0] <= '0;
            srem_reg[0] <= LEN_W'({head.sig, 4'b0000});
            squo_reg[0] <= '0;
        end
    end

    genvar gi;

    // Control and valid line through every stage; the WCA result joins it.
    generate
        for (gi = 1; gi <= STG_LAST; gi++)
        begin : g_line
            back_ctl_t ctl_next;
            logic [79:0] es;

            always_comb
            begin
                ctl_next = ctl_reg[gi-1];
                es       = '0;
                if (gi == STG_WCA_END)
                begin
                    es           = 80'(e0_reg) + (80'(e1_reg) << 32);
                    ctl_next.wca = (ctl_reg[gi-1].wca_en && !ctl_reg[gi-1].s_ovf)
                                   ? es[63:16] : '0;
                    ctl_next.wov = ctl_reg[gi-1].wca_en
                                   && (ctl_reg[gi-1].s_ovf || (es[79:64] != '0));
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[gi] <= 1'b0;
                else if (adv)
                    vld_reg[gi] <= vld_reg[gi-1];
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                    ctl_reg[gi] <= ctl_next;
            end
        end
    endgenerate

    // r^2 / (r0^2 << 16), one restoring step per stage.
    generate
        for (gi = 1; gi <= QDIV_N; gi++)
        begin : g_qdiv
            logic [48:0] rem2, den;
            logic        take;

            always_comb
            begin
                rem2 = {qrem_reg[gi-1], 1'b0};
                den  = {1'b0, ctl_reg[gi-1].r0sq, 16'b0};
                take = (rem2 >= den);
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    qrem_reg[gi] <= take ? 48'(rem2 - den) : rem2[47:0];
                    qquo_reg[gi] <= {qquo_reg[gi-1][30:0], take};
                end
            end
        end
    endgenerate

    // sigma / r in Q.24, known to stay below 2^28 when it is used.
    generate
        for (gi = 1; gi <= SDIV_N; gi++)
        begin : g_sdiv
            logic [LEN_W:0] rem2, dvs;
            logic           take;

            always_comb
            begin
                rem2 = {srem_reg[gi-1], 1'b0};
                dvs  = {1'b0, ctl_reg[gi-1].r};
                take = (rem2 >= dvs);
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    srem_reg[gi] <= take ? LEN_W'(rem2 - dvs) : rem2[LEN_W-1:0];
                    squo_reg[gi] <= {squo_reg[gi-1][SDIV_N-2:0], take};
                end
            end
        end
    endgenerate

    // WCA chain: s^2, s^4, s^6, |2 s^6 - 1|, its square, times epsilon.
    // The square of the difference clamps to all ones when it does not fit 64 bits.
    logic [55:0] s2_full;
    logic [63:0] s4_full;
    logic [71:0] s6_full;
    logic [48:0] two_s6;
    logic [97:0] t2_full;

    always_comb
    begin
        s2_full = squo_reg[SDIV_N] * squo_reg[SDIV_N];
        s4_full = s2_reg * s2_reg;
        s6_full = 72'(plo_reg) + (72'(phi_reg) << 32);
        two_s6  = {s6_reg, 1'b0};
        t2_full = 98'(pll_reg) + (98'(plh_reg) << 33) + (98'(phh_reg) << 64);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_reg    <= s2_full[55:24];
            s4_reg    <= s4_full[63:24];
            s2b_reg   <= s2_reg;
            plo_reg   <= s4_reg[31:0] * s2b_reg;
            phi_reg   <= s4_reg[39:32] * s2b_reg;
            s6_reg    <= s6_full[71:24];
            t_reg     <= (two_s6 >= (49'd1 << 24)) ? two_s6 - (49'd1 << 24)
                                                   : (49'd1 << 24) - two_s6;
            pll_reg   <= t_reg[31:0] * t_reg[31:0];
            plh_reg   <= t_reg[48:32] * t_reg[31:0];
            phh_reg   <= t_reg[48:32] * t_reg[48:32];
            t2_reg    <= (t2_full[97:88] != '0) ? '1 : t2_full[87:24];
            e0_reg    <= ctl_reg[STG_EP-1].eps * t2_reg[31:0];
            e1_reg    <= ctl_reg[STG_EP-1].eps * t2_reg[63:32];
        end
    end

    // y = 1 - q, then normalisation and 28 squaring steps of log2.
    log_t y_next;

    always_comb
    begin
        y_next.m    = 32'(33'h1_0000_0000 - {1'b0, qquo_reg[QDIV_N]});
        y_next.one  = (qquo_reg[QDIV_N] == '0);
        y_next.k    = '0;
        y_next.frac = '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            lg_reg[STG_Y] <= y_next;
    end

    generate
        for (gi = STG_Y + 1; gi <= STG_NORM_LAST; gi++)
        begin : g_norm
            localparam int SH = 1 << (STG_NORM_LAST - gi);
            log_t lg_next;

            always_comb
            begin
                lg_next = lg_reg[gi-1];
                if (lg_reg[gi-1].m[31 -: SH] == '0)
                begin
                    lg_next.m = lg_reg[gi-1].m << SH;
                    lg_next.k = lg_reg[gi-1].k + 5'(SH);
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                    lg_reg[gi] <= lg_next;
            end
        end

        for (gi = STG_NORM_LAST + 1; gi <= STG_SQ_LAST; gi++)
        begin : g_sq
            logic [63:0] sq;
            log_t        lg_next;

            always_comb
            begin
                sq           = lg_reg[gi-1].m * lg_reg[gi-1].m;
                lg_next      = lg_reg[gi-1];
                lg_next.frac = {lg_reg[gi-1].frac[26:0], sq[63]};
                lg_next.m    = sq[63] ? sq[63:32] : sq[62:31];
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                    lg_reg[gi] <= lg_next;
            end
        end
    endgenerate

    // -ln(y) = ln2 * (k + 1 - log2 fraction), then kf*r0^2 * nl >> 41.
    logic [63:0] nl_prod;
    logic [85:0] sp_full;

    always_comb
    begin
        nl_prod = 64'(lsum_reg) * 64'(LN2_Q30) + (64'd1 << 25);
        sp_full = 86'(sp0_reg) + (86'(sp1_reg) << 24);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lsum_reg   <= {6'(lg_reg[STG_SQ_LAST].k) + 6'd1, 28'b0}
                          - {6'b0, lg_reg[STG_SQ_LAST].frac};
            lone_reg   <= lg_reg[STG_SQ_LAST].one;
            nl_reg     <= lone_reg ? '0 : nl_prod[62:26];
            pp0_reg    <= ctl_reg[STG_SP0-1].akr[23:0] * nl_reg[18:0];
            pp1_reg    <= ctl_reg[STG_SP0-1].akr[23:0] * nl_reg[36:19];
            pp2_reg    <= ctl_reg[STG_SP0-1].akr[47:24] * nl_reg[18:0];
            pp3_reg    <= ctl_reg[STG_SP0-1].akr[47:24] * nl_reg[36:19];
            sp0_reg    <= 62'(pp0_reg) + (62'(pp1_reg) << 19);
            sp1_reg    <= 62'(pp2_reg) + (62'(pp3_reg) << 19);
            spring_reg <= sp_full[85:41];
        end
    end

    // Sum and saturation into the output register.
    logic [48:0] total;

    always_comb
    begin
        total = 49'(ctl_reg[STG_LAST].wca) + 49'(spring_reg);
        if (ctl_reg[STG_LAST].spec != ST_OK)
        begin
            energy_next = '1;
            status_next = ctl_reg[STG_LAST].spec;
        end
        else if (ctl_reg[STG_LAST].wov || total[48])
        begin
            energy_next = '1;
            status_next = ST_OVER;
        end
        else
        begin
            energy_next = total[47:0];
            status_next = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= vld_reg[STG_LAST];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            energy_reg <= energy_next;
            status_reg <= status_next;
        end
    end

    a_flag_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (status_reg != ST_OK) |-> energy_reg == '1)
        else $error("flagged result without saturated energy");
    a_last_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        adv && vld_reg[STG_LAST] |=> out_valid_reg)
        else $error("finished bond lost before the output register");

endmodule

`default_nettype wire
